/* hdl/matrix3_inverse_unit_assert.svh */
// Assertion macros for the 3x3 matrix inverse unit
`ifndef MATRIX3_INVERSE_UNIT_ASSERT_SVH
`define MATRIX3_INVERSE_UNIT_ASSERT_SVH

// Same-cycle implication, off during reset
`define M3I_ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked through reset as well
`define M3I_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) (ante) |=> (cons)) else $error(msg);

`endif

/* hdl/m3i_pkg.sv */
// Shared widths, types and constants of the 3x3 matrix inverse unit
package m3i_pkg;

   localparam int DATA_WIDTH = 32;
   localparam int FRAC_BITS  = 16;
   localparam int ELEMS      = 9;
   localparam int ROW_ELEMS  = 3;
   localparam int PROD_W     = 2 * DATA_WIDTH;
   localparam int ADJ_W      = 2 * DATA_WIDTH + 1;
   localparam int HI_W       = ADJ_W - DATA_WIDTH;
   localparam int PP_W       = DATA_WIDTH + HI_W + 1;
   localparam int DET_W      = 3 * DATA_WIDTH + 3;
   localparam int NUM_W      = ADJ_W + 2 * FRAC_BITS;
   localparam int CMP_W      = (NUM_W > DET_W + DATA_WIDTH) ? NUM_W : DET_W + DATA_WIDTH;
   localparam int QUO_W      = DATA_WIDTH + 1;
   localparam int DIV_STAGES = QUO_W;

   typedef logic signed [DATA_WIDTH-1:0] elem_type;
   typedef logic signed [ADJ_W-1:0]      adj_type;
   typedef elem_type [ELEMS-1:0]         mat_type;

   localparam elem_type SAT_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
   localparam elem_type SAT_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};
   localparam logic [QUO_W-1:0] QUO_LIM = {2'b00, {(DATA_WIDTH-1){1'b1}}};

   // operand positions of each cofactor p*q - r*s
   localparam int COF_P [ELEMS] = '{4, 2, 1, 5, 0, 2, 3, 1, 0};
   localparam int COF_Q [ELEMS] = '{8, 7, 5, 6, 8, 3, 7, 6, 4};
   localparam int COF_R [ELEMS] = '{5, 1, 2, 3, 2, 0, 4, 0, 1};
   localparam int COF_S [ELEMS] = '{7, 8, 4, 8, 6, 5, 6, 7, 3};

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_SINGULAR  = 2'd1,
      STATUS_SATURATED = 2'd2
   } status_type;

   typedef struct packed {
      adj_type  [ELEMS-1:0]     adj;
      elem_type [ROW_ELEMS-1:0] row0;
   } cof_type;

   typedef struct packed {
      logic [DET_W-1:0]            dmag;
      logic                        dneg;
      logic                        dzero;
      logic [ELEMS-1:0]            nneg;
      logic [ELEMS-1:0][NUM_W-1:0] nmag;
   } div_in_type;

   typedef struct packed {
      elem_type [ELEMS-1:0] inv;
      status_type           status;
   } rsp_type;

endpackage

/* hdl/m3i_req_if.sv */
// Request channel: one 3x3 matrix per beat
interface m3i_req_if;
   import m3i_pkg::*;

   logic     valid;
   logic     ready;
   elem_type row0_col0;
   elem_type row0_col1;
   elem_type row0_col2;
   elem_type row1_col0;
   elem_type row1_col1;
   elem_type row1_col2;
   elem_type row2_col0;
   elem_type row2_col1;
   elem_type row2_col2;

   modport source (
      output valid, row0_col0, row0_col1, row0_col2, row1_col0, row1_col1, row1_col2,
             row2_col0, row2_col1, row2_col2,
      input  ready
   );
   modport sink (
      input  valid, row0_col0, row0_col1, row0_col2, row1_col0, row1_col1, row1_col2,
             row2_col0, row2_col1, row2_col2,
      output ready
   );
endinterface

/* hdl/m3i_rsp_if.sv */
// Response channel: one inverse matrix and status per beat
interface m3i_rsp_if;
   import m3i_pkg::*;

   logic       valid;
   logic       ready;
   elem_type   inv_row0_col0;
   elem_type   inv_row0_col1;
   elem_type   inv_row0_col2;
   elem_type   inv_row1_col0;
   elem_type   inv_row1_col1;
   elem_type   inv_row1_col2;
   elem_type   inv_row2_col0;
   elem_type   inv_row2_col1;
   elem_type   inv_row2_col2;
   status_type status;

   modport source (
      output valid, inv_row0_col0, inv_row0_col1, inv_row0_col2, inv_row1_col0,
             inv_row1_col1, inv_row1_col2, inv_row2_col0, inv_row2_col1, inv_row2_col2,
             status,
      input  ready
   );
   modport sink (
      input  valid, inv_row0_col0, inv_row0_col1, inv_row0_col2, inv_row1_col0,
             inv_row1_col1, inv_row1_col2, inv_row2_col0, inv_row2_col1, inv_row2_col2,
             status,
      output ready
   );
endinterface

/* hdl/m3i_cofactor.sv */
// Two-stage pipeline forming the nine cofactors of the adjugate
module m3i_cofactor (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  m3i_pkg::mat_type in_mat,
   output logic             out_valid,
   input  logic             out_ready,
   output m3i_pkg::cof_type out_cof
);
   import m3i_pkg::*;

   logic [1:0] valid_ff, valid_in, en;
   logic signed [PROD_W-1:0] pq_ff [ELEMS];
   logic signed [PROD_W-1:0] pq_in [ELEMS];
   logic signed [PROD_W-1:0] rs_ff [ELEMS];
   logic signed [PROD_W-1:0] rs_in [ELEMS];
   elem_type [ROW_ELEMS-1:0] row0_ff;
   cof_type cof_ff, cof_in;

   assign en[1]    = !valid_ff[1] || out_ready;
   assign en[0]    = !valid_ff[0] || en[1];
   assign in_ready = en[0];
   assign valid_in = {valid_ff[0], in_valid};

   for (genvar k = 0; k < ELEMS; k++) begin : g_prod
      assign pq_in[k] = $signed(in_mat[COF_P[k]]) * $signed(in_mat[COF_Q[k]]);
      assign rs_in[k] = $signed(in_mat[COF_R[k]]) * $signed(in_mat[COF_S[k]]);
      assign cof_in.adj[k] = ADJ_W'(pq_ff[k]) - ADJ_W'(rs_ff[k]);
   end
   assign cof_in.row0 = row0_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int i = 0; i < 2; i++) begin
            if (en[i]) begin
               valid_ff[i] <= valid_in[i];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         for (int k = 0; k < ELEMS; k++) begin
            pq_ff[k] <= pq_in[k];
            rs_ff[k] <= rs_in[k];
         end
         row0_ff <= in_mat[ROW_ELEMS-1:0];
      end
      if (en[1]) begin
         cof_ff <= cof_in;
      end
   end

   assign out_valid = valid_ff[1];
   assign out_cof   = cof_ff;
endmodule

/* hdl/m3i_determinant.sv */
// Four-stage pipeline: determinant, its magnitude and the scaled numerators
module m3i_determinant (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  m3i_pkg::cof_type    in_cof,
   output logic                out_valid,
   input  logic                out_ready,
   output m3i_pkg::div_in_type out_div
);
   import m3i_pkg::*;

   logic [3:0] valid_ff, valid_in, en;
   logic signed [PP_W-1:0] plo_ff [ROW_ELEMS];
   logic signed [PP_W-1:0] plo_in [ROW_ELEMS];
   logic signed [PP_W-1:0] phi_ff [ROW_ELEMS];
   logic signed [PP_W-1:0] phi_in [ROW_ELEMS];
   logic signed [DET_W-1:0] term_ff [ROW_ELEMS];
   logic signed [DET_W-1:0] term_in [ROW_ELEMS];
   logic signed [DET_W-1:0] det_ff, det_in;
   logic signed [NUM_W-1:0] num [ELEMS];
   adj_type [ELEMS-1:0] adj3_ff, adj4_ff, adj5_ff;
   div_in_type div_ff, div_in;

   assign en[3] = !valid_ff[3] || out_ready;
   for (genvar i = 0; i < 3; i++) begin : g_en
      assign en[i] = !valid_ff[i] || en[i+1];
   end
   assign in_ready = en[0];
   assign valid_in = {valid_ff[2:0], in_valid};

   for (genvar j = 0; j < ROW_ELEMS; j++) begin : g_term
      assign plo_in[j] = $signed(in_cof.row0[j])
                       * $signed({1'b0, in_cof.adj[3*j][DATA_WIDTH-1:0]});
      assign phi_in[j] = $signed(in_cof.row0[j])
                       * $signed(in_cof.adj[3*j][ADJ_W-1:DATA_WIDTH]);
      assign term_in[j] = (DET_W'(phi_ff[j]) <<< DATA_WIDTH) + DET_W'(plo_ff[j]);
   end
   assign det_in = term_ff[0] + term_ff[1] + term_ff[2];

   always_comb begin
      div_in.dneg  = det_ff[DET_W-1];
      div_in.dzero = (det_ff == '0);
      div_in.dmag  = div_in.dneg ? DET_W'(-det_ff) : DET_W'(det_ff);
      for (int k = 0; k < ELEMS; k++) begin
         num[k]            = NUM_W'(adj5_ff[k]) <<< (2 * FRAC_BITS);
         div_in.nneg[k]    = num[k][NUM_W-1];
         div_in.nmag[k]    = num[k][NUM_W-1] ? NUM_W'(-num[k]) : NUM_W'(num[k]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int i = 0; i < 4; i++) begin
            if (en[i]) begin
               valid_ff[i] <= valid_in[i];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         for (int j = 0; j < ROW_ELEMS; j++) begin
            plo_ff[j] <= plo_in[j];
            phi_ff[j] <= phi_in[j];
         end
         adj3_ff <= in_cof.adj;
      end
      if (en[1]) begin
         for (int j = 0; j < ROW_ELEMS; j++) begin
            term_ff[j] <= term_in[j];
         end
         adj4_ff <= adj3_ff;
      end
      if (en[2]) begin
         det_ff  <= det_in;
         adj5_ff <= adj4_ff;
      end
      if (en[3]) begin
         div_ff <= div_in;
      end
   end

   assign out_valid = valid_ff[3];
   assign out_div   = div_ff;
endmodule

/* hdl/m3i_divider.sv */
// Nine-lane restoring divider, one quotient bit per stage, then saturation
module m3i_divider (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  m3i_pkg::div_in_type in_div,
   output logic                out_valid,
   input  logic                out_ready,
   output m3i_pkg::rsp_type    out_rsp
);
   import m3i_pkg::*;

   logic [DIV_STAGES:0] valid_ff, valid_in, en;
   logic [CMP_W-1:0] rem_ff  [DIV_STAGES][ELEMS];
   logic [CMP_W-1:0] rem_in  [DIV_STAGES][ELEMS];
   logic [CMP_W-1:0] rem_src [DIV_STAGES][ELEMS];
   logic [QUO_W-1:0] quo_ff  [DIV_STAGES][ELEMS];
   logic [QUO_W-1:0] quo_in  [DIV_STAGES][ELEMS];
   logic [QUO_W-1:0] quo_src [DIV_STAGES][ELEMS];
   logic [DET_W-1:0] dmag_ff [DIV_STAGES];
   logic [DET_W-1:0] dmag_src [DIV_STAGES];
   logic [ELEMS-1:0] nneg_ff [DIV_STAGES];
   logic [ELEMS-1:0] nneg_src [DIV_STAGES];
   logic [DIV_STAGES-1:0] dneg_ff, dneg_src, dzero_ff, dzero_src;
   logic [ELEMS-1:0] fin_neg, fin_over;
   logic [QUO_W-1:0] fin_q [ELEMS];
   rsp_type rsp_ff, rsp_in;

   assign en[DIV_STAGES] = !valid_ff[DIV_STAGES] || out_ready;
   for (genvar i = 0; i < DIV_STAGES; i++) begin : g_en
      assign en[i] = !valid_ff[i] || en[i+1];
   end
   assign in_ready = en[0];
   assign valid_in = {valid_ff[DIV_STAGES-1:0], in_valid};

   for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
      if (s == 0) begin : g_first
         assign dmag_src[s]  = in_div.dmag;
         assign dneg_src[s]  = in_div.dneg;
         assign dzero_src[s] = in_div.dzero;
         assign nneg_src[s]  = in_div.nneg;
         for (genvar k = 0; k < ELEMS; k++) begin : g_lane
            assign rem_src[s][k] = CMP_W'(in_div.nmag[k]);
            assign quo_src[s][k] = '0;
         end
      end else begin : g_next
         assign dmag_src[s]  = dmag_ff[s-1];
         assign dneg_src[s]  = dneg_ff[s-1];
         assign dzero_src[s] = dzero_ff[s-1];
         assign nneg_src[s]  = nneg_ff[s-1];
         for (genvar k = 0; k < ELEMS; k++) begin : g_lane
            assign rem_src[s][k] = rem_ff[s-1][k];
            assign quo_src[s][k] = quo_ff[s-1][k];
         end
      end
      for (genvar k = 0; k < ELEMS; k++) begin : g_step
         logic [CMP_W-1:0] shifted;
         logic             ge;
         assign shifted = CMP_W'(dmag_src[s]) << (DATA_WIDTH - s);
         assign ge      = (rem_src[s][k] >= shifted);
         assign rem_in[s][k] = ge ? (rem_src[s][k] - shifted) : rem_src[s][k];
         assign quo_in[s][k] = quo_src[s][k] | (QUO_W'(ge) << (DATA_WIDTH - s));
      end
   end

   always_comb begin
      rsp_in = '0;
      for (int k = 0; k < ELEMS; k++) begin
         fin_q[k]    = quo_ff[DIV_STAGES-1][k];
         fin_neg[k]  = nneg_ff[DIV_STAGES-1][k] ^ dneg_ff[DIV_STAGES-1];
         fin_over[k] = fin_q[k][QUO_W-1]
                     || ({1'b0, fin_q[k][DATA_WIDTH-1:0]} > (QUO_LIM + QUO_W'(fin_neg[k])));
         if (dzero_ff[DIV_STAGES-1]) begin
            rsp_in.inv[k] = '0;
         end else if (fin_over[k]) begin
            rsp_in.inv[k] = fin_neg[k] ? SAT_MIN : SAT_MAX;
         end else if (fin_neg[k]) begin
            rsp_in.inv[k] = elem_type'(-fin_q[k][DATA_WIDTH-1:0]);
         end else begin
            rsp_in.inv[k] = elem_type'(fin_q[k][DATA_WIDTH-1:0]);
         end
      end
      if (dzero_ff[DIV_STAGES-1]) begin
         rsp_in.status = STATUS_SINGULAR;
      end else if (|fin_over) begin
         rsp_in.status = STATUS_SATURATED;
      end else begin
         rsp_in.status = STATUS_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int i = 0; i <= DIV_STAGES; i++) begin
            if (en[i]) begin
               valid_ff[i] <= valid_in[i];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int s = 0; s < DIV_STAGES; s++) begin
         if (en[s]) begin
            dmag_ff[s]  <= dmag_src[s];
            dneg_ff[s]  <= dneg_src[s];
            dzero_ff[s] <= dzero_src[s];
            nneg_ff[s]  <= nneg_src[s];
            for (int k = 0; k < ELEMS; k++) begin
               rem_ff[s][k] <= rem_in[s][k];
               quo_ff[s][k] <= quo_in[s][k];
            end
         end
      end
      if (en[DIV_STAGES]) begin
         rsp_ff <= rsp_in;
      end
   end

   assign out_valid = valid_ff[DIV_STAGES];
   assign out_rsp   = rsp_ff;
endmodule

/* hdl/matrix3_inverse_unit.sv */
// Top level of the pipelined 3x3 matrix inverse unit
//
// Takes one 3x3 matrix of signed Q16.16 entries per beat on req_bus and returns
// its inverse (adjugate over determinant, truncated toward zero, saturated) with
// a status code per beat on rsp_bus. Both channels use valid/ready; a beat moves
// on a rising edge with valid and ready high.
// Path: an accepted request passes the cofactor products, the determinant and
// magnitudes, the restoring division (one quotient bit per stage, nine lanes
// side by side) and one output register before the response goes valid.
// Throughput: one matrix per cycle while rsp_bus.ready is high; every stage
// holds a valid bit and moves on when it is empty or its successor moves,
// so bubbles close up.
// Stall: while rsp_bus.ready is low the response holds; requests are still
// taken until every stage holds a matrix, then req_bus.ready drops.
// Reset: synchronous, active high; clears all valid bits, no results pending.
// A zero determinant returns all-zero entries with status singular; any entry
// clipped to the Q16.16 range returns status saturated.
module matrix3_inverse_unit (
   input logic      clock,
   input logic      reset,
   m3i_req_if.sink   req_bus,
   m3i_rsp_if.source rsp_bus
);
   import m3i_pkg::*;

   mat_type    mat;
   cof_type    cof;
   div_in_type div_data;
   rsp_type    rsp;
   logic       cof_valid, cof_ready, div_valid, div_ready;
   logic       any_limit;

   assign mat[0] = req_bus.row0_col0;
   assign mat[1] = req_bus.row0_col1;
   assign mat[2] = req_bus.row0_col2;
   assign mat[3] = req_bus.row1_col0;
   assign mat[4] = req_bus.row1_col1;
   assign mat[5] = req_bus.row1_col2;
   assign mat[6] = req_bus.row2_col0;
   assign mat[7] = req_bus.row2_col1;
   assign mat[8] = req_bus.row2_col2;

   m3i_cofactor u_cofactor (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_bus.valid),
      .in_ready  (req_bus.ready),
      .in_mat    (mat),
      .out_valid (cof_valid),
      .out_ready (cof_ready),
      .out_cof   (cof)
   );

   m3i_determinant u_determinant (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (cof_valid),
      .in_ready  (cof_ready),
      .in_cof    (cof),
      .out_valid (div_valid),
      .out_ready (div_ready),
      .out_div   (div_data)
   );

   m3i_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (div_valid),
      .in_ready  (div_ready),
      .in_div    (div_data),
      .out_valid (rsp_bus.valid),
      .out_ready (rsp_bus.ready),
      .out_rsp   (rsp)
   );

   assign rsp_bus.inv_row0_col0 = rsp.inv[0];
   assign rsp_bus.inv_row0_col1 = rsp.inv[1];
   assign rsp_bus.inv_row0_col2 = rsp.inv[2];
   assign rsp_bus.inv_row1_col0 = rsp.inv[3];
   assign rsp_bus.inv_row1_col1 = rsp.inv[4];
   assign rsp_bus.inv_row1_col2 = rsp.inv[5];
   assign rsp_bus.inv_row2_col0 = rsp.inv[6];
   assign rsp_bus.inv_row2_col1 = rsp.inv[7];
   assign rsp_bus.inv_row2_col2 = rsp.inv[8];
   assign rsp_bus.status        = rsp.status;

   always_comb begin
      any_limit = 1'b0;
      for (int k = 0; k < ELEMS; k++) begin
         any_limit = any_limit || (rsp.inv[k] == SAT_MAX) || (rsp.inv[k] == SAT_MIN);
      end
   end

`include "matrix3_inverse_unit_assert.svh"

   `M3I_ASSERT_IMPL(a_singular_zero, rsp_bus.valid && rsp.status == STATUS_SINGULAR, rsp.inv == '0, "singular result with nonzero entry")
   `M3I_ASSERT_IMPL(a_saturated_limit, rsp_bus.valid && rsp.status == STATUS_SATURATED, any_limit, "saturated status without limit entry")
   `M3I_ASSERT_IMPL(a_stall_cause, !req_bus.ready, rsp_bus.valid && !rsp_bus.ready, "request stalled without response backpressure")
   `M3I_ASSERT_NEXT(a_reset_empty, reset, !rsp_bus.valid, "response valid right after reset")

endmodule
